[src/uesc_pkg.sv]
package uesc_pkg;

  localparam int unsigned HOLD_DIGITS_DEF = 16;

  localparam logic [7:0] CHR_BSLASH = 8'h5C;
  localparam logic [7:0] CHR_U      = 8'h75;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       string_end;
  } in_word_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       string_last;
    logic       hold_overflow;
  } out_word_t;

  typedef enum logic [2:0] {
    SRC_BSLASH,
    SRC_U,
    SRC_DIGIT,
    SRC_UTF,
    SRC_BYTE
  } src_t;

  typedef struct packed {
    logic accept;
    logic run_store;
    logic run_clear;
    logic emit;
    src_t src;
    logic last;
    logic str_last;
    logic hovf;
  } ctrl_cmd_t;

  typedef struct packed {
    logic in_hex;
    logic in_u;
    logic in_bslash;
    logic in_end;
    logic run_empty;
    logic run_full;
    logic run_ovf;
    logic enc_empty;
    logic dig_last;
    logic utf_last;
    logic out_free;
  } dp_stat_t;

endpackage

[src/uesc_ctrl.sv]
module uesc_ctrl import uesc_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      item_valid,
  output logic      item_ready,
  input  dp_stat_t  stat,
  output ctrl_cmd_t cmd
);

  typedef enum logic [2:0] {
    ST_READY,
    ST_BSLASH,
    ST_U,
    ST_DIGIT,
    ST_UTF,
    ST_BYTE
  } state_t;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_BSLASH,
    PH_DIGITS
  } phase_t;

  localparam int unsigned SEG_BSLASH = 0;
  localparam int unsigned SEG_U      = 1;
  localparam int unsigned SEG_DIGIT  = 2;
  localparam int unsigned SEG_UTF    = 3;
  localparam int unsigned SEG_BYTE   = 4;

  state_t     state;
  phase_t     phase;
  logic [4:0] pend;
  logic       end_q;
  logic       hovf_q;

  phase_t     phase_next;
  logic [4:0] plan;
  logic       plan_hovf;
  logic       plan_store;
  logic       plan_clear;
  logic       accept;
  logic       emitting;
  logic       seg_done;
  logic [4:0] cur_mask;
  logic [4:0] pend_next;
  src_t       src;

  function automatic state_t first_seg(input logic [4:0] p);
    state_t s;
    s = ST_READY;
    if (p[SEG_BYTE]) s = ST_BYTE;
    if (p[SEG_UTF]) s = ST_UTF;
    if (p[SEG_DIGIT]) s = ST_DIGIT;
    if (p[SEG_U]) s = ST_U;
    if (p[SEG_BSLASH]) s = ST_BSLASH;
    return s;
  endfunction

  always_comb begin
    plan       = '0;
    phase_next = phase;
    plan_hovf  = 1'b0;
    plan_store = 1'b0;
    plan_clear = 1'b0;
    case (phase)
      PH_IDLE: begin
        if (stat.in_bslash && !stat.in_end) begin
          phase_next = PH_BSLASH;
        end else begin
          plan[SEG_BYTE] = 1'b1;
          phase_next     = PH_IDLE;
        end
      end
      PH_BSLASH: begin
        if (stat.in_u && !stat.in_end) begin
          phase_next = PH_DIGITS;
          plan_clear = 1'b1;
        end else if (stat.in_bslash && !stat.in_end) begin
          plan[SEG_BSLASH] = 1'b1;
        end else begin
          plan[SEG_BSLASH] = 1'b1;
          plan[SEG_BYTE]   = 1'b1;
          phase_next       = PH_IDLE;
        end
      end
      PH_DIGITS: begin
        if (stat.in_hex) begin
          if (stat.run_full || stat.in_end) begin
            plan[SEG_BSLASH] = 1'b1;
            plan[SEG_U]      = 1'b1;
            plan[SEG_DIGIT]  = !stat.run_empty;
            plan[SEG_BYTE]   = 1'b1;
            plan_hovf        = stat.run_full;
            plan_clear       = 1'b1;
            phase_next       = PH_IDLE;
          end else begin
            plan_store = 1'b1;
          end
        end else begin
          if (stat.run_empty || stat.run_ovf) begin
            plan[SEG_BSLASH] = 1'b1;
            plan[SEG_U]      = 1'b1;
            plan[SEG_DIGIT]  = !stat.run_empty;
          end else begin
            plan[SEG_UTF] = !stat.enc_empty;
          end
          plan_clear = 1'b1;
          if (stat.in_bslash && !stat.in_end) begin
            phase_next = PH_BSLASH;
          end else begin
            plan[SEG_BYTE] = 1'b1;
            phase_next     = PH_IDLE;
          end
        end
      end
      default: begin
        phase_next = PH_IDLE;
      end
    endcase
  end

  always_comb begin
    cur_mask = '0;
    seg_done = 1'b1;
    src      = SRC_BYTE;
    case (state)
      ST_BSLASH: begin
        cur_mask[SEG_BSLASH] = 1'b1;
        src                  = SRC_BSLASH;
      end
      ST_U: begin
        cur_mask[SEG_U] = 1'b1;
        src             = SRC_U;
      end
      ST_DIGIT: begin
        cur_mask[SEG_DIGIT] = 1'b1;
        seg_done            = stat.dig_last;
        src                 = SRC_DIGIT;
      end
      ST_UTF: begin
        cur_mask[SEG_UTF] = 1'b1;
        seg_done          = stat.utf_last;
        src               = SRC_UTF;
      end
      ST_BYTE: begin
        cur_mask[SEG_BYTE] = 1'b1;
        src                = SRC_BYTE;
      end
      default: begin
        seg_done = 1'b0;
      end
    endcase
  end

  assign item_ready = (state == ST_READY);
  assign accept     = item_valid && item_ready;
  assign emitting   = (state != ST_READY) && stat.out_free;
  assign pend_next  = seg_done ? (pend & ~cur_mask) : pend;

  always_comb begin
    cmd           = '0;
    cmd.accept    = accept;
    cmd.run_store = accept && plan_store;
    cmd.run_clear = accept && plan_clear;
    cmd.emit      = emitting;
    cmd.src       = src;
    cmd.last      = seg_done && (pend_next == '0);
    cmd.str_last  = seg_done && (pend_next == '0) && end_q;
    cmd.hovf      = hovf_q;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_READY;
      phase  <= PH_IDLE;
      pend   <= '0;
      end_q  <= 1'b0;
      hovf_q <= 1'b0;
    end else if (accept) begin
      pend   <= plan;
      state  <= first_seg(plan);
      phase  <= phase_next;
      end_q  <= stat.in_end;
      hovf_q <= plan_hovf;
    end else if (emitting) begin
      pend  <= pend_next;
      state <= first_seg(pend_next);
    end
  end

endmodule

[src/uesc_dpath.sv]
module uesc_dpath import uesc_pkg::*; #(
  parameter int unsigned HOLD_DIGITS = HOLD_DIGITS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  in_word_t  item,
  input  ctrl_cmd_t cmd,
  output dp_stat_t  stat,
  output logic      result_valid,
  input  logic      result_ready,
  output out_word_t result
);

  localparam int unsigned CW = $clog2(HOLD_DIGITS + 1);
  localparam int unsigned IW = $clog2(HOLD_DIGITS);

  logic [7:0]    held [HOLD_DIGITS];
  logic [CW-1:0] digit_count;
  logic [31:0]   code_value;
  logic          value_ovf;

  in_word_t      in_q;
  logic [CW-1:0] flush_cnt;
  logic [CW-1:0] rd_ptr;
  logic [7:0]    mem_q;
  logic [3:0][7:0] utf_q;
  logic [2:0]    utf_len;
  logic [1:0]    utf_idx;

  logic          hex_ok;
  logic [3:0]    hex_nib;
  logic [2:0]    enc_len;
  logic [3:0][7:0] enc_bytes;
  logic [CW-1:0] rd_ptr_inc;
  logic [IW-1:0] rd_addr;
  logic          dig_adv;
  logic          utf_adv;
  logic [7:0]    emit_byte;

  always_comb begin
    hex_ok  = 1'b0;
    hex_nib = item.text_byte[3:0];
    if (item.text_byte >= 8'h30 && item.text_byte <= 8'h39) begin
      hex_ok = 1'b1;
    end else if ((item.text_byte >= 8'h61 && item.text_byte <= 8'h66) ||
                 (item.text_byte >= 8'h41 && item.text_byte <= 8'h46)) begin
      hex_ok  = 1'b1;
      hex_nib = item.text_byte[3:0] + 4'd9;
    end
  end

  always_comb begin
    enc_len   = 3'd0;
    enc_bytes = '0;
    if (code_value <= 32'h0000_007F) begin
      enc_len      = 3'd1;
      enc_bytes[0] = code_value[7:0];
    end else if (code_value <= 32'h0000_07FF) begin
      enc_len      = 3'd2;
      enc_bytes[0] = {3'b110, code_value[10:6]};
      enc_bytes[1] = {2'b10, code_value[5:0]};
    end else if (code_value <= 32'h0000_FFFF) begin
      enc_len      = 3'd3;
      enc_bytes[0] = {4'b1110, code_value[15:12]};
      enc_bytes[1] = {2'b10, code_value[11:6]};
      enc_bytes[2] = {2'b10, code_value[5:0]};
    end else if (code_value <= 32'h0010_FFFF) begin
      enc_len      = 3'd4;
      enc_bytes[0] = {5'b11110, code_value[20:18]};
      enc_bytes[1] = {2'b10, code_value[17:12]};
      enc_bytes[2] = {2'b10, code_value[11:6]};
      enc_bytes[3] = {2'b10, code_value[5:0]};
    end
  end

  assign dig_adv    = cmd.emit && (cmd.src == SRC_DIGIT);
  assign utf_adv    = cmd.emit && (cmd.src == SRC_UTF);
  assign rd_ptr_inc = rd_ptr + CW'(1);
  assign rd_addr    = dig_adv ? rd_ptr_inc[IW-1:0] : rd_ptr[IW-1:0];

  always_comb begin
    stat           = '0;
    stat.in_hex    = hex_ok;
    stat.in_u      = (item.text_byte == CHR_U);
    stat.in_bslash = (item.text_byte == CHR_BSLASH);
    stat.in_end    = item.string_end;
    stat.run_empty = (digit_count == '0);
    stat.run_full  = (digit_count == CW'(HOLD_DIGITS));
    stat.run_ovf   = value_ovf;
    stat.enc_empty = (enc_len == 3'd0);
    stat.dig_last  = (rd_ptr_inc == flush_cnt);
    stat.utf_last  = (({1'b0, utf_idx} + 3'd1) == utf_len);
    stat.out_free  = !result_valid || result_ready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      digit_count <= '0;
      code_value  <= '0;
      value_ovf   <= 1'b0;
    end else if (cmd.run_clear) begin
      digit_count <= '0;
      code_value  <= '0;
      value_ovf   <= 1'b0;
    end else if (cmd.run_store) begin
      digit_count <= digit_count + CW'(1);
      value_ovf   <= value_ovf | (code_value[31:28] != 4'd0);
      code_value  <= {code_value[27:0], hex_nib};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.run_store) begin
      held[digit_count[IW-1:0]] <= item.text_byte;
    end
    mem_q <= held[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      in_q      <= item;
      flush_cnt <= digit_count;
      utf_q     <= enc_bytes;
      utf_len   <= enc_len;
      rd_ptr    <= '0;
      utf_idx   <= '0;
    end else begin
      if (dig_adv) begin
        rd_ptr <= rd_ptr_inc;
      end
      if (utf_adv) begin
        utf_idx <= utf_idx + 2'd1;
      end
    end
  end

  always_comb begin
    case (cmd.src)
      SRC_BSLASH: emit_byte = CHR_BSLASH;
      SRC_U:      emit_byte = CHR_U;
      SRC_DIGIT:  emit_byte = mem_q;
      SRC_UTF:    emit_byte = utf_q[utf_idx];
      default:    emit_byte = in_q.text_byte;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.emit) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      result.out_byte      <= emit_byte;
      result.run_last      <= cmd.last;
      result.string_last   <= cmd.str_last;
      result.hold_overflow <= cmd.hovf;
    end
  end

endmodule

[src/unicode_escape_to_utf8_unit.sv]
// Decodes backslash-u escapes in a byte stream into UTF-8. A plain byte is registered on
// acceptance and its word is then written to the output register; a backslash that opens
// an escape or a held hex digit produces no word and item_ready stays high. When an escape
// closes, the controller writes the output register one word per cycle while the consumer
// does not stall; an item yields up to HOLD_DIGITS + 3 words and item_ready stays low until
// its last word is written. Runs longer than HOLD_DIGITS digits are passed through raw with
// hold_overflow set on every word of that item.
module unicode_escape_to_utf8_unit import uesc_pkg::*; #(
  parameter int unsigned HOLD_DIGITS = HOLD_DIGITS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      item_valid,
  output logic      item_ready,
  input  in_word_t  item,
  output logic      result_valid,
  input  logic      result_ready,
  output out_word_t result
);

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  uesc_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .stat       (stat),
    .cmd        (cmd)
  );

  uesc_dpath #(
    .HOLD_DIGITS (HOLD_DIGITS)
  ) u_dpath (
    .clk          (clk),
    .rst          (rst),
    .item         (item),
    .cmd          (cmd),
    .stat         (stat),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule

[src/uesc_checker.sv]
module uesc_checker import uesc_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      item_valid,
  input logic      item_ready,
  input in_word_t  item,
  input logic      result_valid,
  input logic      result_ready,
  input out_word_t result
);

  a_reset_empty: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !result_valid)
    else $error("result word present right after reset");

  a_ready_falls_on_accept: assert property (@(posedge clk) disable iff (rst)
    $fell(item_ready) |-> $past(item_valid && item_ready))
    else $error("input ready dropped without an accepted word");

  a_string_last_run_last: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.string_last |-> result.run_last)
    else $error("string_last set on a word that is not the last of its item");

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("stalled result word changed or vanished");

endmodule

bind unicode_escape_to_utf8_unit uesc_checker u_uesc_checker (.*);

[tb/sv/unicode_escape_to_utf8_unit_test.sv]
`timescale 1ns / 100ps

module unicode_escape_to_utf8_unit_test;
  import uesc_pkg::*;

  localparam int RANDOM_WORDS = 200;
  localparam int LONG_HOLD = 300;
  localparam int LIMIT_CYCLES = 3000000;
  localparam int MAX_REPORTS = 60;

  typedef enum logic [1:0] {
    ESC_IDLE,
    ESC_BSLASH,
    ESC_DIGITS
  } esc_phase_t;

  logic clk = 1'b0;
  logic rst;
  logic item_valid;
  logic item_ready;
  in_word_t item;
  logic result_valid;
  logic result_ready;
  out_word_t result;

  esc_phase_t esc_phase;
  logic [7:0] run_digits [HOLD_DIGITS_DEF];
  int unsigned run_len;
  logic [31:0] run_value;
  logic run_wrapped;

  logic [7:0] step_bytes[$];
  out_word_t decoded_q[$];
  logic [7:0] text_q[$];
  string hex_chars = "0123456789abcdefABCDEF";

  int mismatches = 0;
  int sent_words = 0;
  int checked_words = 0;
  int strings_sent = 0;
  int escapes_encoded = 0;
  int escapes_raw = 0;
  int escapes_dropped = 0;
  int cycles = 0;

  logic send_idle = 1'b0;
  logic recv_idle = 1'b0;
  logic long_hold_req = 1'b0;
  int hold_left = 0;
  int stall_left = 0;

  unicode_escape_to_utf8_unit u_top (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_ready(item_ready),
    .item(item),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result(result)
  );

  always #5 clk = ~clk;

  function automatic int hex_nibble(input logic [7:0] b);
    if (b >= "0" && b <= "9") return int'(b) - int'("0");
    if (b >= "a" && b <= "f") return int'(b) - int'("a") + 10;
    if (b >= "A" && b <= "F") return int'(b) - int'("A") + 10;
    return -1;
  endfunction

  function automatic int random_gap();
    if ($urandom_range(0, 99) < 80) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic void clear_run();
    run_len = 0;
    run_value = '0;
    run_wrapped = 1'b0;
  endfunction

  function automatic void append_raw_escape();
    step_bytes.push_back(CHR_BSLASH);
    step_bytes.push_back(CHR_U);
    for (int i = 0; i < run_len; i++) step_bytes.push_back(run_digits[i]);
    escapes_raw++;
  endfunction

  function automatic void plain_text(input logic [7:0] b, input logic e);
    if (b == CHR_BSLASH && !e) begin
      esc_phase = ESC_BSLASH;
    end else begin
      step_bytes.push_back(b);
      esc_phase = ESC_IDLE;
    end
  endfunction

  function automatic void decode_step(input in_word_t w);
    logic [7:0] b;
    logic e;
    logic hov;
    int nib;
    logic [31:0] v;
    out_word_t o;
    b = w.text_byte;
    e = w.string_end;
    hov = 1'b0;
    step_bytes.delete();
    case (esc_phase)
      ESC_BSLASH: begin
        if (b == CHR_U && !e) begin
          esc_phase = ESC_DIGITS;
          clear_run();
        end else if (b == CHR_BSLASH && !e) begin
          step_bytes.push_back(CHR_BSLASH);
        end else begin
          step_bytes.push_back(CHR_BSLASH);
          step_bytes.push_back(b);
          esc_phase = ESC_IDLE;
        end
      end
      ESC_DIGITS: begin
        nib = hex_nibble(b);
        if (nib >= 0) begin
          if (run_len >= HOLD_DIGITS_DEF || e) begin
            hov = (run_len >= HOLD_DIGITS_DEF);
            append_raw_escape();
            step_bytes.push_back(b);
            esc_phase = ESC_IDLE;
          end else begin
            run_digits[run_len] = b;
            run_len++;
            if (run_value[31:28] != 4'h0) run_wrapped = 1'b1;
            run_value = {run_value[27:0], nib[3:0]};
          end
        end else begin
          v = run_value;
          if (run_len == 0 || run_wrapped) begin
            append_raw_escape();
          end else if (v <= 32'h7F) begin
            step_bytes.push_back(v[7:0]);
            escapes_encoded++;
          end else if (v <= 32'h7FF) begin
            step_bytes.push_back({3'b110, v[10:6]});
            step_bytes.push_back({2'b10, v[5:0]});
            escapes_encoded++;
          end else if (v <= 32'hFFFF) begin
            step_bytes.push_back({4'b1110, v[15:12]});
            step_bytes.push_back({2'b10, v[11:6]});
            step_bytes.push_back({2'b10, v[5:0]});
            escapes_encoded++;
          end else if (v <= 32'h10FFFF) begin
            step_bytes.push_back({5'b11110, v[20:18]});
            step_bytes.push_back({2'b10, v[17:12]});
            step_bytes.push_back({2'b10, v[11:6]});
            step_bytes.push_back({2'b10, v[5:0]});
            escapes_encoded++;
          end else begin
            escapes_dropped++;
          end
          plain_text(b, e);
        end
      end
      default: plain_text(b, e);
    endcase
    if (esc_phase != ESC_DIGITS || e) clear_run();
    if (e) esc_phase = ESC_IDLE;
    foreach (step_bytes[k]) begin
      o.out_byte = step_bytes[k];
      o.run_last = (k == step_bytes.size() - 1);
      o.string_last = o.run_last && e;
      o.hold_overflow = hov;
      decoded_q.push_back(o);
    end
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("mismatch %s at output word %0d: got %0h, expected %0h",
               what, checked_words, got, want);
  endtask

  always @(posedge clk) begin : check_results
    out_word_t want;
    if (!rst && result_valid && result_ready) begin
      if (decoded_q.size() == 0) begin
        report_mismatch("unexpected word", 32'(result), '0);
      end else begin
        want = decoded_q.pop_front();
        if (result.out_byte !== want.out_byte)
          report_mismatch("out_byte", 32'(result.out_byte), 32'(want.out_byte));
        if (result.run_last !== want.run_last)
          report_mismatch("run_last", 32'(result.run_last), 32'(want.run_last));
        if (result.string_last !== want.string_last)
          report_mismatch("string_last", 32'(result.string_last),
                          32'(want.string_last));
        if (result.hold_overflow !== want.hold_overflow)
          report_mismatch("hold_overflow", 32'(result.hold_overflow),
                          32'(want.hold_overflow));
      end
      checked_words++;
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d words still expected",
               cycles, decoded_q.size());
      $display("FAIL unicode_escape_to_utf8_unit");
      $finish;
    end
  end

  // The long hold is counted here so that the sender keeps offering words meanwhile.
  always @(negedge clk) begin
    if (rst) begin
      result_ready <= 1'b0;
    end else begin
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        result_ready <= 1'b0;
      end else begin
        result_ready <= 1'b1;
        if (recv_idle && $urandom_range(0, 99) < 25) stall_left = random_gap();
      end
    end
  end

  task automatic send_word(input logic [7:0] b, input logic e);
    in_word_t w;
    int gap;
    w.text_byte = b;
    w.string_end = e;
    item <= w;
    item_valid <= 1'b1;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    decode_step(w);
    sent_words++;
    @(negedge clk);
    gap = 0;
    if (send_idle && $urandom_range(0, 99) < 30) gap = random_gap();
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic send_text();
    foreach (text_q[i]) send_word(text_q[i], i == text_q.size() - 1);
    if (text_q.size() != 0) strings_sent++;
    text_q.delete();
  endtask

  task automatic push_str(input string s);
    for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
  endtask

  task automatic push_escape(input int nd);
    int zeros;
    text_q.push_back(CHR_BSLASH);
    text_q.push_back(CHR_U);
    zeros = ($urandom_range(0, 99) < 15) ? nd / 2 : 0;
    for (int i = 0; i < nd; i++)
      text_q.push_back(i < zeros ? 8'("0") : hex_chars[$urandom_range(0, 21)]);
  endtask

  task automatic push_non_hex();
    int r;
    logic [7:0] b;
    r = $urandom_range(0, 99);
    if (r < 15) begin
      text_q.push_back(CHR_BSLASH);
    end else if (r < 25) begin
      text_q.push_back(CHR_U);
    end else begin
      b = 8'($urandom_range(0, 255));
      while (hex_nibble(b) >= 0) b = 8'($urandom_range(0, 255));
      text_q.push_back(b);
    end
  endtask

  task automatic add_random_segment();
    int r;
    int nd;
    r = $urandom_range(0, 99);
    if (r < 45) begin
      r = $urandom_range(0, 99);
      if (r < 5) nd = 0;
      else if (r < 60) nd = $urandom_range(1, 4);
      else if (r < 80) nd = $urandom_range(5, 6);
      else if (r < 88) nd = $urandom_range(7, 12);
      else if (r < 94) nd = HOLD_DIGITS_DEF;
      else nd = $urandom_range(HOLD_DIGITS_DEF + 1, HOLD_DIGITS_DEF + 2);
      push_escape(nd);
      if ($urandom_range(0, 99) < 80) push_non_hex();
    end else if (r < 75) begin
      repeat ($urandom_range(1, 4)) text_q.push_back(8'($urandom_range(0, 255)));
    end else if (r < 85) begin
      text_q.push_back(CHR_BSLASH);
      text_q.push_back($urandom_range(0, 1) ? 8'($urandom_range(0, 255)) : CHR_BSLASH);
    end else if (r < 92) begin
      text_q.push_back(CHR_BSLASH);
      text_q.push_back(CHR_BSLASH);
    end else begin
      text_q.push_back(CHR_BSLASH);
      text_q.push_back(CHR_U);
    end
  endtask

  task automatic wait_drained();
    item_valid <= 1'b0;
    while (decoded_q.size() != 0) @(negedge clk);
    repeat (HOLD_DIGITS_DEF + 8) @(negedge clk);
  endtask

  task automatic test_plain_bytes();
    text_q = '{8'h00, 8'hFF, 8'h80, 8'h7F, 8'h01, 8'hFE};
    send_text();
    text_q.push_back("A");
    send_text();
  endtask

  task automatic test_escape_encodings();
    push_str("\\u41;\\u7ff.\\u800 \\uFFFF!\\u10000x\\u10FFFF,\\uD800-\\u110000/");
    send_text();
  endtask

  task automatic test_escape_corners();
    push_str("\\ug\\u123456789;\\u0000000000000041z\\u0123456789abcdef01z");
    send_text();
    push_str("\\a\\\\\\u41 \\u41\\u42\\");
    send_text();
    push_str("x\\u");
    send_text();
    push_str("\\u12");
    send_text();
    push_str("\\");
    send_text();
  endtask

  task automatic test_random_text();
    int start;
    int mode;
    start = sent_words;
    while (sent_words - start < RANDOM_WORDS) begin
      mode = $urandom_range(0, 3);
      send_idle = mode[0];
      recv_idle = mode[1];
      repeat ($urandom_range(1, 6)) add_random_segment();
      send_text();
    end
    send_idle = 1'b0;
    recv_idle = 1'b0;
  endtask

  task automatic test_backpressure();
    wait_drained();
    long_hold_req = 1'b1;
    repeat (4) begin
      repeat (4) begin
        push_escape($urandom_range(4, 6));
        text_q.push_back(";");
      end
      send_text();
    end
    wait_drained();
  endtask

  initial begin
    rst = 1'b1;
    item_valid = 1'b0;
    item = '0;
    result_ready = 1'b0;
    esc_phase = ESC_IDLE;
    clear_run();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_plain_bytes();
    test_escape_encodings();
    test_escape_corners();
    test_backpressure();
    test_random_text();
    wait_drained();
    repeat (40) @(negedge clk);
    $display("Sent %0d input words in %0d strings and checked %0d output words.",
             sent_words, strings_sent, checked_words);
    $display("Escapes: %0d encoded, %0d passed raw, %0d dropped as out of range.",
             escapes_encoded, escapes_raw, escapes_dropped);
    if (mismatches == 0 && decoded_q.size() == 0) begin
      $display("PASS unicode_escape_to_utf8_unit");
    end else begin
      $display("%0d mismatches, %0d words never arrived", mismatches, decoded_q.size());
      $display("FAIL unicode_escape_to_utf8_unit");
    end
    $finish;
  end

endmodule

[filelist.f]
src/uesc_pkg.sv
src/uesc_ctrl.sv
src/uesc_dpath.sv
src/unicode_escape_to_utf8_unit.sv
src/uesc_checker.sv
tb/sv/unicode_escape_to_utf8_unit_test.sv
